// File: design/gf256_arithmetic_unit_assert.svh
// assertion macros shared by the checker of the gf(2^8) arithmetic unit
// expects clk and arst_n in the scope where a macro is used
`ifndef GF256_ARITHMETIC_UNIT_ASSERT_SVH
`define GF256_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define GFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/gfa_pkg.sv
// types, codes and the field multiply shared by the gf(2^8) arithmetic unit
// no dependencies; the other design files but the assertion header use it by scoped names
`default_nettype none

package gfa_pkg;

	localparam logic [1:0] CMD_MUL = 2'd0;
	localparam logic [1:0] CMD_DIV = 2'd1;
	localparam logic [1:0] CMD_INV = 2'd2;

	localparam logic [7:0] POLY_RESET = 8'h1B;
	localparam logic [7:0] FIELD_ONE  = 8'h01;

	// seven square-and-multiply rounds for a^254, one cell per half round
	localparam int NUM_STEPS = 14;

	typedef enum logic {
		STEP_SQR,
		STEP_MUL
	} gfa_step_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
	} gfa_in_t;

	typedef struct packed {
		logic [7:0] result;
		logic       divide_by_zero;
	} gfa_out_t;

	// what travels along the row of cells
	typedef struct packed {
		logic       valid;
		logic [1:0] command;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] s;
		logic [7:0] r;
	} gfa_stage_t;

	// shift-and-add product reduced by x^8 + poly
	function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] poly);
		logic [7:0] acc;
		logic [7:0] sh;
		acc = '0;
		sh  = x;
		for (int i = 0; i < 8; i++) begin
			if (y[i]) begin
				acc = acc ^ sh;
			end
			sh = {sh[6:0], 1'b0} ^ (sh[7] ? poly : 8'h00);
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

// File: design/gf256_arithmetic_unit.sv
// top level of the gf(2^8) multiply / divide / inverse unit
// depends on gfa_pkg, gfa_cell and gfa_final
//
// usage:
//   input channel in_valid / in_stall / in_data carries command, operand_a and
//   operand_b; output channel out_valid / out_stall / out_data carries result and
//   divide_by_zero, one output transaction per input transaction, in order.
//   cfg_wr_en / cfg_wr_data write the low byte of the reduction polynomial
//   (bit 8 implied); write it only while the unit is empty.
// path: a transaction taken at the input passes through fourteen exponent cells
//   (square, multiply, seven times for a^254) and the result cell, each of them
//   registered, before it is shown on the output.
// throughput: one transaction per cycle while the output is not stalled; each cell
//   holds one transaction and hands it on at every edge at which the next cell is ready.
// reset: all cells empty, polynomial back to 0x1B (the aes field).
// stall: a stalled result stays on out_data; cells behind it keep filling
//   bubbles, and in_stall rises only once every cell holds a transaction.
`default_nettype none

module gf256_arithmetic_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [7:0]       cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire gfa_pkg::gfa_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output gfa_pkg::gfa_out_t     out_data
);

	logic [7:0]          poly_q;
	gfa_pkg::gfa_stage_t st [0:gfa_pkg::NUM_STEPS];
	logic                rdy [0:gfa_pkg::NUM_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= gfa_pkg::POLY_RESET;
		end else if (cfg_wr_en) begin
			poly_q <= cfg_wr_data;
		end
	end

	// the exponent base is b for a divide, a otherwise
	always_comb begin
		st[0].valid   = in_valid;
		st[0].command = in_data.command;
		st[0].a       = in_data.operand_a;
		st[0].b       = in_data.operand_b;
		st[0].s       = (in_data.command == gfa_pkg::CMD_DIV) ? in_data.operand_b
			: in_data.operand_a;
		st[0].r       = gfa_pkg::FIELD_ONE;
	end

	assign in_stall = !rdy[0];

	for (genvar i = 0; i < gfa_pkg::NUM_STEPS; i++) begin : g_cell
		gfa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.poly     (poly_q),
			.kind     ((i % 2 == 0) ? gfa_pkg::STEP_SQR : gfa_pkg::STEP_MUL),
			.up       (st[i]),
			.up_ready (rdy[i]),
			.dn       (st[i+1]),
			.dn_ready (rdy[i+1])
		);
	end

	gfa_final u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.poly      (poly_q),
		.up        (st[gfa_pkg::NUM_STEPS]),
		.up_ready  (rdy[gfa_pkg::NUM_STEPS]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// File: design/gfa_cell.sv
// one cell of the exponentiation row: a square or a multiply step of a^254
// depends on gfa_pkg
`default_nettype none

module gfa_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [7:0]         poly,
	input  wire gfa_pkg::gfa_step_t kind,
	input  wire gfa_pkg::gfa_stage_t up,
	output logic                    up_ready,
	output gfa_pkg::gfa_stage_t     dn,
	input  wire logic               dn_ready
);

	logic                valid_q;
	gfa_pkg::gfa_stage_t data_q;
	gfa_pkg::gfa_stage_t step;
	logic [7:0]          prod;

	// cell takes a new transaction when empty or when its content moves on
	assign up_ready = !valid_q || dn_ready;

	always_comb begin
		step = up;
		prod = '0;
		case (kind)
			gfa_pkg::STEP_SQR: begin
				prod   = gfa_pkg::gf_mul(up.s, up.s, poly);
				step.s = prod;
			end
			gfa_pkg::STEP_MUL: begin
				prod   = gfa_pkg::gf_mul(up.r, up.s, poly);
				step.r = prod;
			end
			default: begin
				step = up;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			data_q <= step;
		end
	end

	always_comb begin
		dn       = data_q;
		dn.valid = valid_q;
	end

endmodule

`default_nettype wire

// File: design/gfa_final.sv
// last cell: picks the operation's result and holds it for the receiver
// depends on gfa_pkg
`default_nettype none

module gfa_final (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [7:0]          poly,
	input  wire gfa_pkg::gfa_stage_t up,
	output logic                     up_ready,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output gfa_pkg::gfa_out_t        out_data
);

	logic              valid_q;
	gfa_pkg::gfa_out_t res_q;
	gfa_pkg::gfa_out_t res;
	logic [7:0]        mul_b;
	logic [7:0]        prod;

	assign up_ready = !valid_q || !out_stall;

	// divide multiplies by b^254, multiply by b itself
	assign mul_b = (up.command == gfa_pkg::CMD_DIV) ? up.r : up.b;
	assign prod  = gfa_pkg::gf_mul(up.a, mul_b, poly);

	always_comb begin
		res = '0;
		case (up.command)
			gfa_pkg::CMD_MUL: res.result = prod;
			gfa_pkg::CMD_DIV: begin
				res.result         = prod;
				res.divide_by_zero = (up.b == 8'h00);
			end
			gfa_pkg::CMD_INV: res.result = up.r;
			default:          res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = res_q;

endmodule

`default_nettype wire

// File: design/gfa_checker.sv
// port-level checks of the gf(2^8) arithmetic unit, bound to the top level
// depends on gfa_pkg and gf256_arithmetic_unit_assert.svh
`default_nettype none

`include "gf256_arithmetic_unit_assert.svh"

module gfa_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire gfa_pkg::gfa_out_t out_data
);

	`GFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output transaction changed")

	`GFA_ASSERT_NOW(a_dz_zero, out_valid && out_data.divide_by_zero, out_data.result == 8'h00, "divide by zero with nonzero result")

	// the input may only back up once the whole row is full behind a stalled output
	`GFA_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

	`GFA_ASSERT_NEXT(a_drain, !in_valid && !out_valid, !in_stall, "input stalled while the unit drains")

endmodule

bind gf256_arithmetic_unit gfa_checker u_gfa_checker (.*);

`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for gf256_arithmetic_unit: multiply, divide and inverse over GF(2^8)
// depends on gfa_pkg and the unit itself; results are predicted here for the current polynomial
`timescale 1ns / 100ps

module testbench;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic     in_valid = 1'b0;
	logic     in_stall;
	gfa_pkg::gfa_in_t  in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	gfa_pkg::gfa_out_t out_data;

	// polynomial low byte as seen by the predictor
	logic [7:0] field_poly = gfa_pkg::POLY_RESET;
	gfa_pkg::gfa_out_t expected_field_results[$];
	bit         idle_enabled = 1'b1;
	bit         valid_held = 1'b0;
	int         error_count = 0;
	int         operations_sent = 0;
	int         results_checked = 0;
	int         polys_used = 1;
	int         quiet_cycles = 0;

	gf256_arithmetic_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// product modulo x^8 + poly, horner form from the top bit of y
	function automatic logic [7:0] ring_product(input logic [7:0] x, input logic [7:0] y,
			input logic [7:0] poly);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 7; i >= 0; i--) begin
			acc = {acc[6:0], 1'b0} ^ (acc[7] ? poly : 8'h00);
			if (y[i]) begin
				acc = acc ^ x;
			end
		end
		return acc;
	endfunction

	// x^254, the inverse when the polynomial is irreducible
	function automatic logic [7:0] ring_power254(input logic [7:0] x, input logic [7:0] poly);
		logic [7:0] r;
		logic [7:0] s;
		r = gfa_pkg::FIELD_ONE;
		s = x;
		for (int i = 0; i < 7; i++) begin
			s = ring_product(s, s, poly);
			r = ring_product(r, s, poly);
		end
		return r;
	endfunction

	function automatic gfa_pkg::gfa_out_t field_outcome(input gfa_pkg::gfa_in_t op,
			input logic [7:0] poly);
		gfa_pkg::gfa_out_t res;
		res = '0;
		case (op.command)
			gfa_pkg::CMD_MUL: begin
				res.result = ring_product(op.operand_a, op.operand_b, poly);
			end
			gfa_pkg::CMD_DIV: begin
				if (op.operand_b == 8'h00) begin
					res.divide_by_zero = 1'b1;
				end else if (op.operand_a != 8'h00) begin
					res.result = ring_product(op.operand_a,
						ring_power254(op.operand_b, poly), poly);
				end
			end
			gfa_pkg::CMD_INV: begin
				if (op.operand_a != 8'h00) begin
					res.result = ring_power254(op.operand_a, poly);
				end
			end
			default: begin
				res = '0;
			end
		endcase
		return res;
	endfunction

	// mostly random bytes, with the edge values showing up now and then
	function automatic logic [7:0] random_operand();
		logic [7:0] edges[4];
		edges = '{8'h00, 8'h01, 8'h80, 8'hFF};
		if ($urandom_range(7) == 0) begin
			return edges[2'($urandom_range(3))];
		end
		return 8'($urandom_range(255));
	endfunction

	// prediction on input transactions, comparison on output transactions
	always @(posedge clk) begin
		gfa_pkg::gfa_out_t want;
		if (arst_n && in_valid && !in_stall) begin
			expected_field_results.push_back(field_outcome(in_data, field_poly));
			operations_sent++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_field_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("%0t: result %h / dbz %b with nothing outstanding", $realtime,
						out_data.result, out_data.divide_by_zero);
				end
			end else begin
				want = expected_field_results.pop_front();
				results_checked++;
				if (out_data.result !== want.result
						|| out_data.divide_by_zero !== want.divide_by_zero) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("%0t: mismatch: expected result %h dbz %b, got result %h dbz %b",
							$realtime, want.result, want.divide_by_zero,
							out_data.result, out_data.divide_by_zero);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= idle_enabled && ($urandom_range(99) < 27);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	task automatic send_operation(input logic [1:0] cmd, input logic [7:0] a,
			input logic [7:0] b);
		gfa_pkg::gfa_in_t op;
		op.command   = cmd;
		op.operand_a = a;
		op.operand_b = b;
		in_valid <= 1'b1;
		in_data  <= op;
		valid_held = 1'b1;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		// each idle cycle is drawn on its own
		while (idle_enabled && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_pipeline();
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
		@(posedge clk);
		while (expected_field_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// only written with the unit empty
	task automatic set_polynomial(input logic [7:0] poly);
		drain_pipeline();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= poly;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		field_poly = poly;
		polys_used++;
	endtask

	task automatic send_random_operations(input int count);
		logic [3:0] pick;
		logic [1:0] cmd;
		for (int i = 0; i < count; i++) begin
			pick = 4'($urandom_range(15));
			if (pick < 5) begin
				cmd = gfa_pkg::CMD_MUL;
			end else if (pick < 10) begin
				cmd = gfa_pkg::CMD_DIV;
			end else if (pick < 15) begin
				cmd = gfa_pkg::CMD_INV;
			end else begin
				cmd = CMD_UNUSED;
			end
			send_operation(cmd, random_operand(), random_operand());
		end
	endtask

	// edges of the operands, each command, zero divisor and zero inverse in the aes field
	task automatic test_directed_cases();
		send_operation(gfa_pkg::CMD_MUL, 8'h00, 8'h00);
		send_operation(gfa_pkg::CMD_MUL, 8'hFF, 8'hFF);
		send_operation(gfa_pkg::CMD_MUL, 8'h53, 8'hCA);
		send_operation(gfa_pkg::CMD_MUL, 8'h80, 8'h02);
		send_operation(gfa_pkg::CMD_MUL, 8'h00, 8'h57);
		send_operation(gfa_pkg::CMD_MUL, 8'h01, 8'hA5);
		send_operation(gfa_pkg::CMD_DIV, 8'h57, 8'h00);
		send_operation(gfa_pkg::CMD_DIV, 8'h00, 8'h00);
		send_operation(gfa_pkg::CMD_DIV, 8'h00, 8'h05);
		send_operation(gfa_pkg::CMD_DIV, 8'hFF, 8'hFF);
		send_operation(gfa_pkg::CMD_DIV, 8'h01, 8'h53);
		send_operation(gfa_pkg::CMD_DIV, 8'hFF, 8'h01);
		send_operation(gfa_pkg::CMD_INV, 8'h00, 8'h00);
		send_operation(gfa_pkg::CMD_INV, 8'h00, 8'hFF);
		send_operation(gfa_pkg::CMD_INV, 8'h01, 8'h00);
		send_operation(gfa_pkg::CMD_INV, 8'h53, 8'h00);
		send_operation(gfa_pkg::CMD_INV, 8'hFF, 8'h00);
		send_operation(gfa_pkg::CMD_INV, 8'h80, 8'hC3);
		send_operation(CMD_UNUSED, 8'hFF, 8'hFF);
		send_operation(CMD_UNUSED, 8'h00, 8'h00);
		send_operation(CMD_UNUSED, 8'h5A, 8'h00);
	endtask

	task automatic test_aes_field();
		set_polynomial(8'h1B);
		send_random_operations(140);
	endtask

	task automatic test_other_field();
		set_polynomial(8'h1D);
		send_random_operations(100);
	endtask

	// reducible rings at both ends of the register range
	task automatic test_reducible_rings();
		set_polynomial(8'h00);
		send_random_operations(60);
		set_polynomial(8'hFF);
		send_random_operations(60);
	endtask

	// no gaps on either side, so the unit runs back to back
	task automatic test_full_rate();
		set_polynomial(8'($urandom_range(255)));
		idle_enabled = 1'b0;
		send_random_operations(100);
		drain_pipeline();
		idle_enabled = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_aes_field();
		test_other_field();
		test_reducible_rings();
		test_full_rate();
		drain_pipeline();
		repeat (20) @(posedge clk);
		$display("covered %0d operations over %0d polynomial settings, %0d results checked",
			operations_sent, polys_used, results_checked);
		$display("including zero divisors, zero inverses, the unused command and reducible rings");
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d failures", error_count);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: gf256_arithmetic_unit.f
+incdir+design
design/gfa_pkg.sv
design/gfa_cell.sv
design/gfa_final.sv
design/gf256_arithmetic_unit.sv
design/gfa_checker.sv
tb/sv/testbench.sv
